### rtl/ccfs_pkg.sv
// ----------------------------------------------------------------------------
// ccfs_pkg
// Shared types, constants, the month length table and the stamp packing function for the calendar clock.
// ----------------------------------------------------------------------------
package ccfs_pkg;

    localparam int unsigned YEAR_W   = 12;
    localparam int unsigned YOFF_W   = 7;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned HOUR_W   = 5;
    localparam int unsigned MINUTE_W = 6;
    localparam int unsigned SECOND_W = 6;
    localparam int unsigned STAMP_W  = 32;

    localparam logic [YEAR_W-1:0]   BASE_YEAR  = 12'd1980;
    localparam logic [SECOND_W-1:0] SECOND_MAX = 6'd59;
    localparam logic [MINUTE_W:0]   MINUTE_MAX = 7'd59;
    localparam logic [HOUR_W:0]     HOUR_MAX   = 6'd23;
    localparam logic [MONTH_W:0]    MONTH_MAX  = 5'd12;
    localparam logic [MONTH_W-1:0]  FEBRUARY   = 4'd2;

    // item kinds
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_SET  = 1'b1;

    // calendar counters
    typedef struct packed {
        logic [YOFF_W-1:0]   year_offset;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
    } cal_t;

    // one input transaction
    typedef struct packed {
        logic                kind;
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
    } item_t;

    // days in a month; invalid months have length zero
    function automatic logic [DAY_W-1:0] month_length(
        input logic [MONTH_W-1:0] month,
        input logic [YOFF_W-1:0]  year_offset
    );
        logic [DAY_W-1:0] len;
        case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = 5'd28;
            default:                                    len = 5'd0;
        endcase
        // leap year: offset from a leap base year divisible by four
        if (month == FEBRUARY && year_offset[1:0] == 2'b00) begin
            len = 5'd29;
        end
        return len;
    endfunction

    // packed date-time word
    function automatic logic [STAMP_W-1:0] fat_pack(input cal_t c);
        return {c.year_offset, c.month, c.day, c.hour, c.minute,
                c.second[SECOND_W-1:1]};
    endfunction

endpackage

### rtl/calendar_clock_fat_stamp.sv
// ----------------------------------------------------------------------------
// calendar_clock_fat_stamp
// Real-time calendar clock with a packed date-time result per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_*): each transaction is a one-second tick (s_kind = 0)
//   or a set command (s_kind = 1) carrying year, month, day, hour, minute
//   and second. Result channel (m_*): exactly one result per input
//   transaction, in order: the packed date-time after that item and the
//   clock-valid flag. The stamp reads zero until the first set command.
//   Each transaction passes through the input register, then the result
//   register, from which its result is offered.
//   Throughput: one transaction per cycle while m_ready is high; the whole
//   cascade is settled between the two registers.
//   Reset (aresetn low, synchronous): counters clear to zero, the clock
//   reads as never set, both pipeline registers empty.
//   Stall: when m_ready is low the result register holds; the input
//   register still takes one more transaction, then s_ready drops until
//   the receiver drains the result.
// ----------------------------------------------------------------------------
module calendar_clock_fat_stamp
    import ccfs_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_kind,
    input  logic [YEAR_W-1:0]   s_set_year,
    input  logic [MONTH_W-1:0]  s_set_month,
    input  logic [DAY_W-1:0]    s_set_day,
    input  logic [HOUR_W-1:0]   s_set_hour,
    input  logic [MINUTE_W-1:0] s_set_minute,
    input  logic [SECOND_W-1:0] s_set_second,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STAMP_W-1:0]  m_fat_stamp,
    output logic                m_clock_valid
);

    logic                in_valid_reg;
    item_t               in_item_reg;
    cal_t                cal_reg;
    cal_t                cal_next;
    logic                time_valid_reg;
    logic                time_valid_next;
    logic                out_valid_reg;
    logic [STAMP_W-1:0]  out_stamp_reg;
    logic [STAMP_W-1:0]  out_stamp_next;
    logic                out_clock_valid_reg;
    logic                advance;
    logic                s_fire;

    // pipeline flow control
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_fire  = s_valid && s_ready;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_fire) begin
            in_item_reg <= '{kind: s_kind, year: s_set_year, month: s_set_month,
                             day: s_set_day, hour: s_set_hour,
                             minute: s_set_minute, second: s_set_second};
        end
    end

    ccfs_next u_next (
        .item (in_item_reg),
        .cur  (cal_reg),
        .nxt  (cal_next)
    );

    assign time_valid_next = time_valid_reg || (in_item_reg.kind == KIND_SET);
    assign out_stamp_next  = time_valid_next ? fat_pack(cal_next) : '0;

    // calendar state, committed as a transaction moves to the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_reg        <= '0;
            time_valid_reg <= 1'b0;
        end else if (advance) begin
            cal_reg        <= cal_next;
            time_valid_reg <= time_valid_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            out_valid_reg <= in_valid_reg;
        end
        if (advance) begin
            out_stamp_reg       <= out_stamp_next;
            out_clock_valid_reg <= time_valid_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_fat_stamp   = out_stamp_reg;
    assign m_clock_valid = out_clock_valid_reg;

`ifndef NO_ASSERTIONS
    // once set, the clock stays set
    assert property (@(posedge aclk) disable iff (!aresetn)
        time_valid_reg |=> time_valid_reg)
        else $error("clock valid flag dropped");

    // an unset clock never shows a stamp
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_clock_valid) |-> (m_fat_stamp == '0))
        else $error("stamp nonzero while clock not set");

    // a tick always leaves the second counter in range
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_item_reg.kind == KIND_TICK) |=> (cal_reg.second <= SECOND_MAX))
        else $error("second counter out of range after tick");

    // an item moved forward shows up as a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("advanced transaction lost");

    // a held input item is not dropped
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("stalled input transaction dropped");
`endif

endmodule

### rtl/ccfs_next.sv
// ----------------------------------------------------------------------------
// ccfs_next
// Next calendar state: load on a set transaction, carry cascade on a tick.
// ----------------------------------------------------------------------------
module ccfs_next
    import ccfs_pkg::*;
(
    input  item_t item,
    input  cal_t  cur,
    output cal_t  nxt
);

    logic                sec_carry;
    logic [MINUTE_W:0]   min_sum;
    logic                min_carry;
    logic [HOUR_W:0]     hour_sum;
    logic                hour_carry;
    logic [DAY_W:0]      day_sum;
    logic                day_carry;
    logic [MONTH_W:0]    month_sum;
    logic                month_carry;
    logic [DAY_W-1:0]    cur_len;
    logic [YEAR_W-1:0]   year_diff;
    cal_t                tick_cal;

    // tick cascade, the seconds stage adds one and each later stage adds the carry, then each checks its limit
    always_comb begin
        sec_carry   = (cur.second >= SECOND_MAX);
        min_sum     = {1'b0, cur.minute} + {{MINUTE_W{1'b0}}, sec_carry};
        min_carry   = (min_sum > MINUTE_MAX);
        hour_sum    = {1'b0, cur.hour} + {{HOUR_W{1'b0}}, min_carry};
        hour_carry  = (hour_sum > HOUR_MAX);
        day_sum     = {1'b0, cur.day} + {{DAY_W{1'b0}}, hour_carry};
        cur_len     = month_length(cur.month, cur.year_offset);
        day_carry   = (day_sum > {1'b0, cur_len});
        month_sum   = {1'b0, cur.month} + {{MONTH_W{1'b0}}, day_carry};
        month_carry = (month_sum > MONTH_MAX);

        tick_cal.second      = sec_carry ? '0 : cur.second + 6'd1;
        tick_cal.minute      = min_carry ? '0 : min_sum[MINUTE_W-1:0];
        tick_cal.hour        = hour_carry ? '0 : hour_sum[HOUR_W-1:0];
        tick_cal.day         = day_carry ? 5'd1 : day_sum[DAY_W-1:0];
        tick_cal.month       = month_carry ? 4'd1 : month_sum[MONTH_W-1:0];
        tick_cal.year_offset = month_carry ? cur.year_offset + 7'd1 : cur.year_offset;
    end

    // set load, year kept as a wrapping offset from the base year
    always_comb begin
        year_diff = item.year - BASE_YEAR;
        if (item.kind == KIND_SET) begin
            nxt.year_offset = year_diff[YOFF_W-1:0];
            nxt.month       = item.month;
            nxt.day         = item.day;
            nxt.hour        = item.hour;
            nxt.minute      = item.minute;
            nxt.second      = item.second;
        end else begin
            nxt = tick_cal;
        end
    end

endmodule
